/* rtl/core/moving_segment_intersection_test_macros.svh */
// assertion macros used by the segment intersection top level
`ifndef MOVING_SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define MOVING_SEGMENT_INTERSECTION_TEST_MACROS_SVH
`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define MSIT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("msit assertion failed");
// condition never seen outside reset
`define MSIT_ASSERT_NEVER(lbl, cond) \
  `MSIT_ASSERT(lbl, !(cond))
`else
`define MSIT_ASSERT(lbl, prop)
`define MSIT_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/core/msit_pkg.sv */
// shared types, constants and width helpers for the segment intersection block
`default_nettype none
package msit_pkg;

  localparam int CoordWidthDef = 16;
  localparam int EpsW          = 16;
  localparam int TsW           = 16;
  localparam int EpsShift      = 24;
  localparam int TsShift       = 16;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 16;
  localparam int QueueDepthDef = 2;

  // one time unit of the step field, i.e. one second
  localparam logic [TsW:0] TsScale = 17'h10000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE = 1'b0,
    CFG_EPS  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic            continuous_mode;
    logic [EpsW-1:0] parallel_epsilon;
  } cfg_t;

  localparam logic            ModeRst = 1'b1;
  localparam logic [EpsW-1:0] EpsRst  = 16'd1;

  // width of one classified word held in the queue
  function automatic int entry_width(input int w);
    return 3 * (2 * w + 1) + 2 * (2 * w + 2) + TsW + 1;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/moving_segment_intersection_test.sv */
// top level of the moving segment pair intersection test
//
// One word is a pair of 2D segments (start plus direction, signed Q4.12),
// the velocity of the second relative to the first and a time step dt.
// A word is taken at a rising edge with start high and busy low; the block
// takes a new word on every cycle. Each word gives one result: valid_o
// rises once the word has passed through the pipeline and stays high for
// exactly one cycle, with hit_o and near_parallel_o alongside. Results
// leave in the order taken. The pipeline is the capture and cross product
// stages in the front end, the queue stage and the five stage back end,
// whose wide window compares run through split multipliers. The receiver
// cannot hold results off; the back end drains the queue every cycle, so
// the queue never fills and busy stays low. Configuration: cfg_we_i with
// cfg_idx_i (0 mode, 1 epsilon) and cfg_wdata_i, which the user must have
// written only while no word is in flight; the block does not enforce it.
// Reset clears the pipeline and sets continuous mode with epsilon one.
`default_nettype none
module moving_segment_intersection_test #(
  parameter int COORD_WIDTH = msit_pkg::CoordWidthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cfg_we_i,
  input  wire logic [msit_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [msit_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire logic signed [COORD_WIDTH-1:0]     start_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     start_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     dir_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     dir_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     start_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     start_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     dir_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     dir_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     rel_vel_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     rel_vel_y_i,
  input  wire logic [msit_pkg::TsW-1:0]          time_step_i,
  output logic                                   valid_o,
  output logic                                   hit_o,
  output logic                                   near_parallel_o
);
  import msit_pkg::*;

  `include "moving_segment_intersection_test_macros.svh"

  localparam int EW = entry_width(COORD_WIDTH);

  // configuration registers
  logic            mode_q;
  logic [EpsW-1:0] eps_q;
  cfg_t            cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeRst;
      eps_q  <= EpsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE: mode_q <= cfg_wdata_i[0];
        CFG_EPS:  eps_q  <= cfg_wdata_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{continuous_mode: mode_q, parallel_epsilon: eps_q};

  // front end
  logic          take, push, q_full, q_empty;
  logic [EW-1:0] f_entry, q_entry;

  assign take = start && !busy;
  assign busy = q_full;

  msit_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .take_i(take),
    .cfg_i(cfg),
    .start_a_x_i, .start_a_y_i, .dir_a_x_i, .dir_a_y_i,
    .start_b_x_i, .start_b_y_i, .dir_b_x_i, .dir_b_y_i,
    .rel_vel_x_i, .rel_vel_y_i, .time_step_i,
    .push_o(push),
    .entry_o(f_entry)
  );

  // queue between the two halves
  msit_queue #(.WIDTH(EW), .DEPTH(QueueDepthDef)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push),
    .data_i(f_entry),
    .pop_i(!q_empty),
    .full_o(q_full),
    .empty_o(q_empty),
    .data_o(q_entry)
  );

  // back end
  msit_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .cfg_i(cfg),
    .valid_i(!q_empty),
    .entry_i(q_entry),
    .valid_o,
    .hit_o,
    .near_parallel_o
  );

  // checks
  `MSIT_ASSERT_NEVER(a_queue_never_full, busy)
  `MSIT_ASSERT(a_fixed_latency, take |-> ##8 valid_o)
  `MSIT_ASSERT(a_hit_excludes_parallel, valid_o && hit_o |-> !near_parallel_o)

endmodule
`default_nettype wire

/* rtl/core/msit_front.sv */
// front end: input capture, cross products and parallel classification
`default_nettype none
module msit_front #(
  parameter int COORD_WIDTH = msit_pkg::CoordWidthDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  take_i,
  input  wire msit_pkg::cfg_t                        cfg_i,
  input  wire logic signed [COORD_WIDTH-1:0]         start_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]         start_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]         dir_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]         dir_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]         start_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]         start_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]         dir_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]         dir_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]         rel_vel_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]         rel_vel_y_i,
  input  wire logic [msit_pkg::TsW-1:0]              time_step_i,
  output logic                                       push_o,
  output logic [msit_pkg::entry_width(COORD_WIDTH)-1:0] entry_o
);
  import msit_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int PW  = 2 * W;
  localparam int DW  = 2 * W + 1;
  localparam int NRW = 2 * W + 2;
  localparam int DXW = W + 1;

  // capture stage
  logic                  s1_valid_q;
  logic signed [W-1:0]   rax_q, ray_q, sbx_q, sby_q, vx_q, vy_q;
  logic signed [DXW-1:0] dx_q, dy_q;
  logic [TsW-1:0]        ts1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rax_q <= dir_a_x_i;
    ray_q <= dir_a_y_i;
    sbx_q <= dir_b_x_i;
    sby_q <= dir_b_y_i;
    vx_q  <= rel_vel_x_i;
    vy_q  <= rel_vel_y_i;
    dx_q  <= DXW'(start_b_x_i) - DXW'(start_a_x_i);
    dy_q  <= DXW'(start_b_y_i) - DXW'(start_a_y_i);
    ts1_q <= time_step_i;
  end

  // cross products
  logic signed [PW-1:0] p_d0, p_d1, p_vs0, p_vs1, p_vr0, p_vr1;
  logic signed [PW:0]   p_ns0, p_ns1, p_nr0, p_nr1;

  assign p_d0  = rax_q * sby_q;
  assign p_d1  = ray_q * sbx_q;
  assign p_ns0 = dx_q * sby_q;
  assign p_ns1 = dy_q * sbx_q;
  assign p_nr0 = dx_q * ray_q;
  assign p_nr1 = dy_q * rax_q;
  assign p_vs0 = vx_q * sby_q;
  assign p_vs1 = vy_q * sbx_q;
  assign p_vr0 = vx_q * ray_q;
  assign p_vr1 = vy_q * rax_q;

  logic                  s2_valid_q;
  logic signed [DW-1:0]  d_q, vs_q, vr_q;
  logic signed [NRW-1:0] ns_q, nr_q;
  logic [TsW-1:0]        ts2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= DW'(p_d0) - DW'(p_d1);
    ns_q  <= NRW'(p_ns0) - NRW'(p_ns1);
    nr_q  <= NRW'(p_nr0) - NRW'(p_nr1);
    vs_q  <= DW'(p_vs0) - DW'(p_vs1);
    vr_q  <= DW'(p_vr0) - DW'(p_vr1);
    ts2_q <= ts1_q;
  end

  // orient so the denominator is non-negative, then flag near parallel pairs
  logic                  flip;
  logic [DW-1:0]         d_abs;
  logic                  near_par;
  logic signed [NRW-1:0] ns_c, nr_c;
  logic signed [DW-1:0]  vs_c, vr_c;

  always_comb begin
    flip     = d_q[DW-1];
    d_abs    = flip ? DW'(-d_q) : DW'(d_q);
    near_par = d_abs <= DW'(cfg_i.parallel_epsilon);
    ns_c     = flip ? -ns_q : ns_q;
    nr_c     = flip ? -nr_q : nr_q;
    vs_c     = flip ? -vs_q : vs_q;
    vr_c     = flip ? -vr_q : vr_q;
  end

  assign push_o  = s2_valid_q;
  assign entry_o = {near_par, ts2_q, vr_c, vs_c, nr_c, ns_c, d_abs};

endmodule
`default_nettype wire

/* rtl/core/msit_queue.sv */
// short word queue between the front end and the back end
`default_nettype none
module msit_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = msit_pkg::QueueDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/msit_wmul.sv */
// two stage wide signed multiplier built from four half width partial products
`default_nettype none
module msit_wmul #(
  parameter int AW = 35,
  parameter int BW = 35
) (
  input  wire logic                 clk_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0]   p_o
);
  localparam int HA = AW / 2;
  localparam int HB = BW / 2;
  localparam int PW = AW + BW;

  logic signed [AW-HA-1:0] ah;
  logic signed [BW-HB-1:0] bh;
  logic [HA-1:0]           al;
  logic [HB-1:0]           bl;

  assign ah = $signed(a_i[AW-1:HA]);
  assign bh = $signed(b_i[BW-1:HB]);
  assign al = a_i[HA-1:0];
  assign bl = b_i[HB-1:0];

  // partial products
  logic signed [AW-HA+BW-HB-1:0] p_hh_q;
  logic signed [AW-HA+HB:0]      p_hl_q;
  logic signed [HA+BW-HB:0]      p_lh_q;
  logic [HA+HB-1:0]              p_ll_q;

  always_ff @(posedge clk_i) begin
    p_hh_q <= ah * bh;
    p_hl_q <= ah * $signed({1'b0, bl});
    p_lh_q <= $signed({1'b0, al}) * bh;
    p_ll_q <= al * bl;
  end

  // recombine
  always_ff @(posedge clk_i) begin
    p_o <= (PW'(p_hh_q) <<< (HA + HB)) + (PW'(p_hl_q) <<< HA)
         + (PW'(p_lh_q) <<< HB) + PW'(p_ll_q);
  end

endmodule
`default_nettype wire

/* rtl/core/msit_back.sv */
// back end: per constraint time windows and their intersection with [0,dt]
`default_nettype none
module msit_back #(
  parameter int COORD_WIDTH = msit_pkg::CoordWidthDef
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire msit_pkg::cfg_t                           cfg_i,
  input  wire logic                                     valid_i,
  input  wire logic [msit_pkg::entry_width(COORD_WIDTH)-1:0] entry_i,
  output logic                                          valid_o,
  output logic                                          hit_o,
  output logic                                          near_parallel_o
);
  import msit_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int DW  = 2 * W + 1;
  localparam int NRW = 2 * W + 2;
  localparam int NW  = 2 * W + 3;
  localparam int EDW = DW + EpsW;
  localparam int TW  = DW + EpsShift;
  localparam int LW  = NW + TsW + 1;

  typedef struct packed {
    logic signed [NW-1:0] ln;
    logic signed [NW-1:0] hn;
    logic signed [NW-1:0] den;
    logic                 empty;
    logic                 in_range;
  } cons_t;

  // window of t for one constraint, as lo = ln/den and hi = hn/den
  function automatic cons_t solve_c(input logic signed [NRW-1:0] n,
                                    input logic [DW-1:0] d,
                                    input logic [DW-1:0] av,
                                    input logic neg,
                                    input logic tiny,
                                    input logic [TsW-1:0] ts);
    logic signed [NW-1:0] nn;
    logic signed [NW-1:0] dd;
    cons_t r;
    nn = NW'(n);
    dd = $signed(NW'(d));
    r.in_range = !nn[NW-1] && (nn <= dd);
    if (tiny) begin
      r.ln    = '0;
      r.hn    = $signed(NW'(ts));
      r.den   = $signed(NW'(TsScale));
      r.empty = !r.in_range;
    end else if (!neg) begin
      r.ln    = -nn;
      r.hn    = dd - nn;
      r.den   = $signed(NW'(av));
      r.empty = 1'b0;
    end else begin
      r.ln    = nn - dd;
      r.hn    = nn;
      r.den   = $signed(NW'(av));
      r.empty = 1'b0;
    end
    return r;
  endfunction

  // unpack the queue word
  logic [DW-1:0]         e_d;
  logic signed [NRW-1:0] e_ns, e_nr;
  logic signed [DW-1:0]  e_vs, e_vr;
  logic [TsW-1:0]        e_ts;
  logic                  e_np;

  assign {e_np, e_ts, e_vr, e_vs, e_nr, e_ns, e_d} = entry_i;

  // stage 1: rate magnitudes and the epsilon scaled denominator
  logic           b1_valid_q;
  logic [DW-1:0]  b1_d_q, b1_avs_q, b1_avr_q;
  logic signed [NRW-1:0] b1_ns_q, b1_nr_q;
  logic           b1_negs_q, b1_negr_q, b1_zs_q, b1_zr_q, b1_np_q;
  logic [EDW-1:0] b1_epsd_q;
  logic [TsW-1:0] b1_ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_d_q    <= e_d;
    b1_ns_q   <= e_ns;
    b1_nr_q   <= e_nr;
    b1_avs_q  <= e_vs[DW-1] ? DW'(-e_vs) : DW'(e_vs);
    b1_avr_q  <= e_vr[DW-1] ? DW'(-e_vr) : DW'(e_vr);
    b1_negs_q <= e_vs[DW-1];
    b1_negr_q <= e_vr[DW-1];
    b1_zs_q   <= e_vs == '0;
    b1_zr_q   <= e_vr == '0;
    b1_epsd_q <= EDW'(cfg_i.parallel_epsilon) * EDW'(e_d);
    b1_ts_q   <= e_ts;
    b1_np_q   <= e_np;
  end

  // stage 2: near-zero rate test and window bounds
  logic tiny_s, tiny_r;

  assign tiny_s = b1_zs_q || ((TW'(b1_avs_q) << EpsShift) < TW'(b1_epsd_q));
  assign tiny_r = b1_zr_q || ((TW'(b1_avr_q) << EpsShift) < TW'(b1_epsd_q));

  logic           b2_valid_q;
  cons_t          b2_c1_q, b2_c2_q;
  logic [TsW-1:0] b2_ts_q;
  logic           b2_np_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q <= 1'b0;
    end else begin
      b2_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b2_c1_q <= solve_c(b1_ns_q, b1_d_q, b1_avs_q, b1_negs_q, tiny_s, b1_ts_q);
    b2_c2_q <= solve_c(b1_nr_q, b1_d_q, b1_avr_q, b1_negr_q, tiny_r, b1_ts_q);
    b2_ts_q <= b1_ts_q;
    b2_np_q <= b1_np_q;
  end

  // cross compares of the two windows, through the registered wide multipliers
  logic signed [2*NW-1:0] x_l1d2, x_h2d1, x_l2d1, x_h1d2;

  msit_wmul #(.AW(NW), .BW(NW)) u_mul_l1d2 (
    .clk_i, .a_i($signed(b2_c1_q.ln)), .b_i($signed(b2_c2_q.den)), .p_o(x_l1d2)
  );
  msit_wmul #(.AW(NW), .BW(NW)) u_mul_h2d1 (
    .clk_i, .a_i($signed(b2_c2_q.hn)), .b_i($signed(b2_c1_q.den)), .p_o(x_h2d1)
  );
  msit_wmul #(.AW(NW), .BW(NW)) u_mul_l2d1 (
    .clk_i, .a_i($signed(b2_c2_q.ln)), .b_i($signed(b2_c1_q.den)), .p_o(x_l2d1)
  );
  msit_wmul #(.AW(NW), .BW(NW)) u_mul_h1d2 (
    .clk_i, .a_i($signed(b2_c1_q.hn)), .b_i($signed(b2_c2_q.den)), .p_o(x_h1d2)
  );

  // stage 3: step length scaled by each denominator
  logic signed [LW-1:0] tden1_d, tden2_d;

  assign tden1_d = $signed({1'b0, b2_ts_q}) * $signed(b2_c1_q.den);
  assign tden2_d = $signed({1'b0, b2_ts_q}) * $signed(b2_c2_q.den);

  logic                 b3_valid_q;
  logic signed [LW-1:0] b3_td1_q, b3_td2_q;
  logic signed [NW-1:0] b3_ln1_q, b3_ln2_q;
  logic                 b3_hnpos_q, b3_empty_q, b3_static_q, b3_np_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b3_valid_q <= 1'b0;
    end else begin
      b3_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b3_td1_q    <= tden1_d;
    b3_td2_q    <= tden2_d;
    b3_ln1_q    <= $signed(b2_c1_q.ln);
    b3_ln2_q    <= $signed(b2_c2_q.ln);
    b3_hnpos_q  <= !b2_c1_q.hn[NW-1] && !b2_c2_q.hn[NW-1];
    b3_empty_q  <= b2_c1_q.empty || b2_c2_q.empty;
    b3_static_q <= b2_c1_q.in_range && b2_c2_q.in_range;
    b3_np_q     <= b2_np_q;
  end

  // stage 4: each lower bound against dt
  logic b4_valid_q;
  logic b4_look_q, b4_hnpos_q, b4_empty_q, b4_static_q, b4_np_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b4_valid_q <= 1'b0;
    end else begin
      b4_valid_q <= b3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b4_look_q   <= ((LW'(b3_ln1_q) <<< TsShift) <= b3_td1_q)
                && ((LW'(b3_ln2_q) <<< TsShift) <= b3_td2_q);
    b4_hnpos_q  <= b3_hnpos_q;
    b4_empty_q  <= b3_empty_q;
    b4_static_q <= b3_static_q;
    b4_np_q     <= b3_np_q;
  end

  // stage 5: combine and register the result word
  logic cont_hit;

  assign cont_hit = !b4_empty_q && b4_hnpos_q && b4_look_q
                 && (x_l1d2 <= x_h2d1) && (x_l2d1 <= x_h1d2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= b4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o           <= !b4_np_q && (cfg_i.continuous_mode ? cont_hit : b4_static_q);
    near_parallel_o <= b4_np_q;
  end

endmodule
`default_nettype wire
